[design/cpd_pkg.sv]
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants for the correlation peak detector: payload
// words, per-block state and configuration register indexes.
// ----------------------------------------------------------------------------
package cpd_pkg;

   // Field widths fixed by the sample and result formats
   localparam int SAMPLE_WIDTH    = 16;
   localparam int MAG_WIDTH       = SAMPLE_WIDTH;
   localparam int CONF_WIDTH      = 16;
   localparam int HOLD_WIDTH      = 12;
   localparam int COUNT_WIDTH     = 16;
   localparam int POS_OUT_WIDTH   = 16;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam int DEFAULT_MAX_SAMPLES = 65536;

   // Register reset values
   localparam logic [CONF_WIDTH-1:0] CONF_RESET = CONF_WIDTH'(26214);
   localparam logic [HOLD_WIDTH-1:0] HOLD_RESET = HOLD_WIDTH'(16);

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONFIDENCE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLDOFF    = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           last;
   } req_payload_type;

   typedef struct packed {
      logic                     decided;
      logic                     is_match;
      logic [POS_OUT_WIDTH-1:0] judged_index;
      logic [COUNT_WIDTH-1:0]   match_count;
      logic [POS_OUT_WIDTH-1:0] first_match_res;
      logic [POS_OUT_WIDTH-1:0] last_match;
      logic                     any_match;
      logic                     block_done;
   } rsp_payload_type;

   // Per-block detector state (position travels separately, its width
   // follows the block length)
   typedef struct packed {
      logic [MAG_WIDTH-1:0]     prev_mag;
      logic [MAG_WIDTH-1:0]     centre_mag;
      logic [HOLD_WIDTH-1:0]    holdoff_cnt;
      logic [COUNT_WIDTH-1:0]   count_found;
      logic [POS_OUT_WIDTH-1:0] first_pos;
      logic [POS_OUT_WIDTH-1:0] latest_pos;
      logic                     found;
   } block_state_type;

endpackage

[design/cpd_judge.sv]
// ----------------------------------------------------------------------------
// cpd_judge
// Single-pass decision logic: magnitude of the new sample, peak and holdoff
// test on the centre sample, next block state and the result word.
// ----------------------------------------------------------------------------
module cpd_judge #(
   parameter int   MAX_SAMPLES = cpd_pkg::DEFAULT_MAX_SAMPLES,
   localparam int  POS_WIDTH   = $clog2(MAX_SAMPLES)
) (
   input  cpd_pkg::block_state_type                cur_state,
   input  logic [POS_WIDTH-1:0]                    position,
   input  cpd_pkg::req_payload_type                req_word,
   input  logic [cpd_pkg::CONF_WIDTH-1:0]          confidence,
   input  logic [cpd_pkg::HOLD_WIDTH-1:0]          holdoff,
   output cpd_pkg::block_state_type                next_state,
   output logic [POS_WIDTH-1:0]                    next_position,
   output cpd_pkg::rsp_payload_type                result
);
   import cpd_pkg::*;

   localparam logic [POS_WIDTH-1:0] MAX_POS = POS_WIDTH'(MAX_SAMPLES - 1);

   logic [SAMPLE_WIDTH-1:0]          raw;
   logic [MAG_WIDTH-1:0]             cur_mag;
   logic                             candidate;
   logic [POS_WIDTH-1:0]             judged;
   logic [POS_WIDTH+POS_OUT_WIDTH-1:0] judged_ext;
   logic [POS_OUT_WIDTH-1:0]         judged16;
   logic [HOLD_WIDTH-1:0]            hold_dec;
   logic                             matched;

   // Exact magnitude: the most negative code maps to 2^(w-1)
   assign raw     = SAMPLE_WIDTH'(req_word.sample);
   assign cur_mag = raw[SAMPLE_WIDTH-1] ? MAG_WIDTH'(~raw + 1'b1) : raw;

   // Centre sample has both neighbours once two samples are in
   assign candidate  = (position >= POS_WIDTH'(2));
   assign judged     = position - POS_WIDTH'(1);
   assign judged_ext = {{POS_OUT_WIDTH{1'b0}}, judged};
   assign judged16   = judged_ext[POS_OUT_WIDTH-1:0];

   assign hold_dec = (cur_state.holdoff_cnt != '0) ?
                     cur_state.holdoff_cnt - 1'b1 : cur_state.holdoff_cnt;

   assign matched = candidate &&
                    ({1'b0, cur_state.centre_mag} >= {1'b0, confidence}) &&
                    (cur_state.prev_mag < cur_state.centre_mag) &&
                    (cur_mag < cur_state.centre_mag) &&
                    (hold_dec == '0);

   // Next state
   always_comb begin
      next_state            = cur_state;
      next_state.prev_mag   = cur_state.centre_mag;
      next_state.centre_mag = cur_mag;
      if (candidate) begin
         next_state.holdoff_cnt = hold_dec;
      end
      if (matched) begin
         next_state.holdoff_cnt = holdoff;
         next_state.latest_pos  = judged16;
         next_state.found       = 1'b1;
         if (!cur_state.found) begin
            next_state.first_pos = judged16;
         end
         if (cur_state.count_found != {COUNT_WIDTH{1'b1}}) begin
            next_state.count_found = cur_state.count_found + 1'b1;
         end
      end
      next_position = (position < MAX_POS) ? position + 1'b1 : position;
   end

   // Result word reports the updated statistics
   always_comb begin
      result.decided         = candidate;
      result.is_match        = matched;
      result.judged_index    = candidate ? judged16 : '0;
      result.match_count     = next_state.count_found;
      result.first_match_res = next_state.first_pos;
      result.last_match      = next_state.latest_pos;
      result.any_match       = next_state.found;
      result.block_done      = req_word.last;
   end

endmodule

[design/correlation_peak_detector.sv]
// ----------------------------------------------------------------------------
// correlation_peak_detector
// Peak detector with holdoff over blocks of signed correlation samples.
// ----------------------------------------------------------------------------
// Takes one sample word per clock and returns one result word per sample,
// in the cycle after acceptance, from a result register. The block state and
// the result register update in the same cycle, so throughput is one word
// per cycle whenever the result side keeps taking words; a stalled result
// register holds the input off. Each result carries the verdict on the
// previous sample (a sample needs both neighbours), the running match count
// and the first and latest match positions. A word flagged last closes the
// block and the state returns to its reset values for the next block.
// Registers (confidence, holdoff) should be written only while idle.
// ----------------------------------------------------------------------------
module correlation_peak_detector #(
   parameter int MAX_SAMPLES = cpd_pkg::DEFAULT_MAX_SAMPLES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample words in
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cpd_pkg::req_payload_type             req_payload,
   // result words out
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cpd_pkg::rsp_payload_type             rsp_payload,
   // register writes
   input  logic                                 csr_we,
   input  logic [cpd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cpd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import cpd_pkg::*;

   localparam int POS_WIDTH = $clog2(MAX_SAMPLES);

   logic [CONF_WIDTH-1:0] conf_ff, conf_in;
   logic [HOLD_WIDTH-1:0] hold_ff, hold_in;
   block_state_type       state_ff, state_in, judge_state;
   logic [POS_WIDTH-1:0]  pos_ff, pos_in, judge_pos;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in, judge_result;
   logic                  req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   cpd_judge #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_judge (
      .cur_state     (state_ff),
      .position      (pos_ff),
      .req_word      (req_payload),
      .confidence    (conf_ff),
      .holdoff       (hold_ff),
      .next_state    (judge_state),
      .next_position (judge_pos),
      .result        (judge_result)
   );

   // Register writes
   always_comb begin
      conf_in = conf_ff;
      hold_in = hold_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CONFIDENCE: conf_in = csr_wdata[CONF_WIDTH-1:0];
            CSR_HOLDOFF:    hold_in = csr_wdata[HOLD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Block state and result register
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (req_fire) begin
         state_in       = req_payload.last ? '0 : judge_state;
         pos_in         = req_payload.last ? '0 : judge_pos;
         rsp_valid_in   = 1'b1;
         rsp_payload_in = judge_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_ff      <= CONF_RESET;
         hold_ff      <= HOLD_RESET;
         state_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         conf_ff      <= conf_in;
         hold_ff      <= hold_in;
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // Input only held off by a stalled result
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready))
      else $error("req_ready low without a stalled result");

   // Last word clears the block
   a_block_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.last) |=> (pos_ff == '0 && state_ff == '0))
      else $error("block state not cleared after last word");

   // Match count and match flag agree
   a_count_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.any_match ==
                        (rsp_payload_ff.match_count != '0)))
      else $error("match_count and any_match disagree");

   // A match is a decision and becomes the latest match
   a_match_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.is_match) |->
         (rsp_payload_ff.decided &&
          rsp_payload_ff.last_match == rsp_payload_ff.judged_index))
      else $error("match not recorded as latest position");

   // A match reloads the holdoff counter
   a_hold_reload: assert property (@(posedge clock) disable iff (reset)
      (req_fire && judge_result.is_match && !req_payload.last) |=>
         (state_ff.holdoff_cnt == $past(hold_ff)))
      else $error("holdoff counter not reloaded on match");
`endif

endmodule

[tb/cpd_peak_checker.sv]
// ----------------------------------------------------------------------------
// cpd_peak_checker
// Watches the sample and result channels of the correlation peak detector,
// predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
// Register writes are snooped from the write port so the prediction uses
// the same confidence and holdoff settings as the block. Every accepted
// sample word queues one predicted verdict; every accepted result word is
// checked against the oldest one. The failure count and the number of
// verdicts still waiting are handed to the testbench top.
// ----------------------------------------------------------------------------
module cpd_peak_checker #(
   parameter int MAX_SAMPLES = cpd_pkg::DEFAULT_MAX_SAMPLES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  cpd_pkg::req_payload_type             req_payload,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  cpd_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_we,
   input  logic [cpd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cpd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output int                                   mismatches,
   output int                                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import cpd_pkg::*;

   // Only the first failures are printed, all of them are counted
   localparam int PRINT_LIMIT = 30;

   // Register copies
   logic [CONF_WIDTH-1:0]    conf_reg;
   logic [HOLD_WIDTH-1:0]    hold_reg;

   // Per-block detector state
   logic [MAG_WIDTH-1:0]     prev_mag;
   logic [MAG_WIDTH-1:0]     centre_mag;
   logic [HOLD_WIDTH-1:0]    hold_left;
   int                       blk_pos;
   logic [COUNT_WIDTH-1:0]   peak_count;
   int                       first_peak;
   int                       latest_peak;
   logic                     any_peak;

   rsp_payload_type          expected_verdicts[$];
   int                       words_checked;

   function automatic void start_block();
      prev_mag    = '0;
      centre_mag  = '0;
      hold_left   = '0;
      blk_pos     = 0;
      peak_count  = '0;
      first_peak  = 0;
      latest_peak = 0;
      any_peak    = 1'b0;
   endfunction

   // Verdict on the centre sample, now that its right neighbour has come
   function automatic rsp_payload_type judge_sample(req_payload_type w);
      logic [MAG_WIDTH-1:0] mag;
      rsp_payload_type      r;
      logic                 hit;
      int                   jpos;
      mag = w.sample[SAMPLE_WIDTH-1] ? MAG_WIDTH'(~w.sample + 1'b1) : MAG_WIDTH'(w.sample);
      r   = '0;
      hit = 1'b0;
      if (blk_pos >= 2) begin
         jpos = blk_pos - 1;
         r.decided      = 1'b1;
         r.judged_index = POS_OUT_WIDTH'(jpos);
         if (hold_left != 0)
            hold_left = hold_left - 1'b1;
         if (centre_mag >= conf_reg && prev_mag < centre_mag && mag < centre_mag &&
             hold_left == 0) begin
            hit = 1'b1;
            if (!any_peak)
               first_peak = jpos;
            any_peak    = 1'b1;
            latest_peak = jpos;
            // count sticks at its top value
            if (peak_count != '1)
               peak_count = peak_count + 1'b1;
            hold_left = hold_reg;
         end
      end
      prev_mag   = centre_mag;
      centre_mag = mag;
      if (blk_pos < MAX_SAMPLES - 1)
         blk_pos++;
      r.is_match        = hit;
      r.match_count     = peak_count;
      r.first_match_res = POS_OUT_WIDTH'(first_peak);
      r.last_match      = POS_OUT_WIDTH'(latest_peak);
      r.any_match       = any_peak;
      r.block_done      = w.last;
      if (w.last)
         start_block();
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t ns: result word %0d: %s", $realtime, words_checked, msg);
   endtask

   task automatic compare_field(string name, longint got, longint want);
      if (got != want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   // Snoop writes, predict on sample words, check result words
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         conf_reg = CONF_RESET;
         hold_reg = HOLD_RESET;
         start_block();
         expected_verdicts.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CONFIDENCE)
               conf_reg = csr_wdata[CONF_WIDTH-1:0];
            else if (csr_index == CSR_HOLDOFF)
               hold_reg = csr_wdata[HOLD_WIDTH-1:0];
         end
         if (req_valid && req_ready)
            expected_verdicts.push_back(judge_sample(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("result word with no sample word waiting");
            end else begin
               want = expected_verdicts.pop_front();
               compare_field("decided", rsp_payload.decided, want.decided);
               compare_field("is_match", rsp_payload.is_match, want.is_match);
               compare_field("judged_index", rsp_payload.judged_index, want.judged_index);
               compare_field("match_count", rsp_payload.match_count, want.match_count);
               compare_field("first_match_res", rsp_payload.first_match_res,
                             want.first_match_res);
               compare_field("last_match", rsp_payload.last_match, want.last_match);
               compare_field("any_match", rsp_payload.any_match, want.any_match);
               compare_field("block_done", rsp_payload.block_done, want.block_done);
            end
            words_checked++;
         end
      end
      outstanding = expected_verdicts.size();
   end

endmodule

[tb/tb_correlation_peak_detector.sv]
// ----------------------------------------------------------------------------
// tb_correlation_peak_detector
// Stimulus and verdict for the correlation peak detector.
// ----------------------------------------------------------------------------
// A short directed run covers short blocks, extreme samples and the
// confidence extremes, then blocks of random length and content run under
// several register settings with random gaps on both channels, a long
// result stall and a drain pause. The checker beside the block does all
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_correlation_peak_detector;
   timeunit 1ns;
   timeprecision 1ps;

   import cpd_pkg::*;

   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_WORDS = 115;

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_ready;
   req_payload_type             req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_ready   = 1'b0;
   rsp_payload_type             rsp_payload;
   logic                        csr_we      = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index   = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_wdata   = '0;

   int                          mismatches;
   int                          outstanding;

   bit                          idle_on      = 1'b1;
   int                          holds_asked  = 0;
   int                          holds_served = 0;
   logic [CONF_WIDTH-1:0]       cur_conf     = CONF_RESET;
   logic signed [15:0]          prev_sent    = '0;

   correlation_peak_detector #(
      .MAX_SAMPLES (DEFAULT_MAX_SAMPLES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   cpd_peak_checker #(
      .MAX_SAMPLES (DEFAULT_MAX_SAMPLES)
   ) i_peak_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Result side: random stalls, plus long hold-offs on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            holds_served++;
            for (n = 0; n < HOLD_CYCLES; n++) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= !(idle_on && $urandom_range(99) < 18);
      end
   end

   // Both registers in back-to-back cycles; the block must be idle
   task automatic apply_settings(input int conf, input int hold);
      csr_we    <= 1'b1;
      csr_index <= CSR_CONFIDENCE;
      csr_wdata <= CSR_DATA_WIDTH'(conf);
      @(posedge clock);
      csr_index <= CSR_HOLDOFF;
      csr_wdata <= CSR_DATA_WIDTH'(hold);
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_conf  = CONF_WIDTH'(conf);
   endtask

   // Offer one sample word and hold it until taken
   task automatic send_word(input logic signed [15:0] s, input logic l);
      req_payload_type w;
      w.sample = s;
      w.last   = l;
      while (idle_on && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      prev_sent   = s;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Stop offering and wait for every predicted result word
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   // Signed sample of a given magnitude, sign at random
   function automatic logic signed [15:0] signed_mag(input int m);
      logic signed [15:0] s;
      s = 16'(m);
      if (m != 32768 && $urandom_range(1))
         s = -s;
      return s;
   endfunction

   function automatic logic signed [15:0] pick_sample();
      int m;
      case ($urandom_range(9))
         0: return 16'($urandom);
         1: begin
            case ($urandom_range(3))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         2, 3: begin
            // magnitudes close to the threshold
            m = int'(cur_conf) + int'($urandom_range(200)) - 100;
            if (m < 0) m = 0;
            if (m > 32768) m = 32768;
            return signed_mag(m);
         end
         4: return prev_sent;   // equal neighbours
         default: return signed_mag($urandom_range(32768));
      endcase
   endfunction

   function automatic int pick_len();
      case ($urandom_range(9))
         0: return $urandom_range(1, 3);
         1: return $urandom_range(30, 60);
         default: return $urandom_range(4, 25);
      endcase
   endfunction

   task automatic send_block(input int len);
      int i;
      for (i = 0; i < len; i++)
         send_word(pick_sample(), i == len - 1);
   endtask

   initial begin
      int p, conf, hold, sent, len;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: short blocks, full-scale samples, holdoff, threshold extremes
      apply_settings(1000, 2);
      send_word(-16'sd32768, 1'b1);
      send_word(16'sd32767, 1'b0);
      send_word(-16'sd1, 1'b1);
      send_word(16'sd0, 1'b0);
      send_word(16'sd5000, 1'b0);
      send_word(16'sd100, 1'b0);
      send_word(-16'sd6000, 1'b0);
      send_word(16'sd200, 1'b0);
      send_word(16'sd7000, 1'b0);
      send_word(-16'sd32768, 1'b0);
      send_word(16'sd32767, 1'b0);
      send_word(16'sd0, 1'b1);
      wait_drained();
      apply_settings(32768, 0);
      send_word(16'sd0, 1'b0);
      send_word(-16'sd32768, 1'b0);
      send_word(16'sd0, 1'b0);
      send_word(16'sd32767, 1'b0);
      send_word(16'sd1, 1'b1);
      wait_drained();
      // threshold beyond any magnitude
      apply_settings(65535, 4095);
      send_word(16'sd0, 1'b0);
      send_word(-16'sd32768, 1'b0);
      send_word(16'sd0, 1'b1);
      wait_drained();

      // Random blocks under a series of settings
      for (p = 0; p < 7; p++) begin
         case (p)
            0: begin conf = 0;     hold = 0;    end
            1: begin conf = 32768; hold = 4095; end
            2: begin conf = int'(CONF_RESET); hold = int'(HOLD_RESET); end
            3: begin conf = $urandom_range(20000); hold = $urandom_range(8); end
            4: begin conf = $urandom_range(32768); hold = $urandom_range(4095); end
            5: begin conf = 12000; hold = 3; end
            default: begin conf = 0; hold = 1; end
         endcase
         apply_settings(conf, hold);
         // one setting runs without any gaps on either side
         idle_on = (p != 5);
         if (p == 6)
            holds_asked++;
         sent = 0;
         while (sent < PHASE_WORDS) begin
            len = pick_len();
            send_block(len);
            sent += len;
            if (p == 3 && sent == len)
               wait_drained();
         end
         wait_drained();
      end
      idle_on = 1'b1;

      // A last ordinary block under the reset settings
      apply_settings(int'(CONF_RESET), int'(HOLD_RESET));
      send_block(20);
      wait_drained();
      repeat (5) @(posedge clock);

      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
